@@ rtl/core/prr_pkg.sv @@
// ============================================================================
// prr_pkg - shared types and constants of the progress percent reporter
// Percentage constants, the quotient step operations and the pipeline
// control word.
// ============================================================================
package prr_pkg;

    localparam int PCT_W = 7;
    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

    // One operation of the shift-and-add build of w * 100 over the bits of 100.
    typedef enum logic [0:0] {
        OP_DOUBLE = 1'b0,
        OP_ADD    = 1'b1
    } t_op;

    // The first bit of 100 leaves r = w, q = 0; these follow it.
    localparam int NUM_STEPS = 8;
    localparam t_op STEP_OPS [NUM_STEPS] = '{
        OP_DOUBLE, OP_ADD,              // bit 5
        OP_DOUBLE,                      // bit 4
        OP_DOUBLE,                      // bit 3
        OP_DOUBLE, OP_ADD,              // bit 2
        OP_DOUBLE,                      // bit 1
        OP_DOUBLE                       // bit 0
    };

    typedef struct packed {
        logic             valid;
        logic             zero_total;
        logic             full;
        logic [PCT_W-1:0] last;
    } t_ctl;

endpackage

@@ rtl/core/prr_step.sv @@
// ============================================================================
// prr_step - one registered step of the scaled quotient
// Doubles the partial product or adds the written count, reducing modulo
// the total and shifting the quotient digit in, or adding it on an add.
// ============================================================================
module prr_step #(
    parameter int COUNT_BITS = 32,
    parameter prr_pkg::t_op OP = prr_pkg::OP_DOUBLE
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  prr_pkg::t_ctl           i_ctl,
    input  logic [COUNT_BITS-1:0]   i_t,
    input  logic [COUNT_BITS-1:0]   i_w,
    input  logic [COUNT_BITS-1:0]   i_tw,
    input  logic [COUNT_BITS-1:0]   i_r,
    input  logic [prr_pkg::PCT_W-1:0] i_q,
    output prr_pkg::t_ctl           o_ctl,
    output logic [COUNT_BITS-1:0]   o_t,
    output logic [COUNT_BITS-1:0]   o_w,
    output logic [COUNT_BITS-1:0]   o_tw,
    output logic [COUNT_BITS-1:0]   o_r,
    output logic [prr_pkg::PCT_W-1:0] o_q
);
    import prr_pkg::*;

    t_ctl                  r_ctl;
    logic [COUNT_BITS-1:0] r_t, r_w, r_tw, r_r;
    logic [PCT_W-1:0]      r_q;
    logic [COUNT_BITS-1:0] n_r;
    logic [PCT_W-1:0]      n_q;
    logic [COUNT_BITS-1:0] s_gap;

    always_comb begin
        // Remaining room below the total for the amount to be added.
        s_gap = (OP == OP_DOUBLE) ? (i_t - i_r) : i_tw;
        if (i_r >= s_gap) begin
            n_r = i_r - s_gap;
            n_q = (OP == OP_DOUBLE) ? {i_q[PCT_W-2:0], 1'b1} : (i_q + PCT_W'(1));
        end else begin
            n_r = (OP == OP_DOUBLE) ? {i_r[COUNT_BITS-2:0], 1'b0} : (i_r + i_w);
            n_q = (OP == OP_DOUBLE) ? {i_q[PCT_W-2:0], 1'b0} : i_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else begin
            r_ctl.valid <= i_ctl.valid;
        end
        r_ctl.zero_total <= i_ctl.zero_total;
        r_ctl.full       <= i_ctl.full;
        r_ctl.last       <= i_ctl.last;
        r_t  <= i_t;
        r_w  <= i_w;
        r_tw <= i_tw;
        r_r  <= n_r;
        r_q  <= n_q;
    end

    assign o_ctl = r_ctl;
    assign o_t   = r_t;
    assign o_w   = r_w;
    assign o_tw  = r_tw;
    assign o_r   = r_r;
    assign o_q   = r_q;

endmodule

@@ rtl/core/prr_decide.sv @@
// ============================================================================
// prr_decide - final percentage and report decision
// Picks zero, full or the quotient and compares the rise against the step.
// ============================================================================
module prr_decide (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  prr_pkg::t_ctl              i_ctl,
    input  logic [prr_pkg::PCT_W-1:0]  i_q,
    input  logic [prr_pkg::PCT_W-1:0]  i_step,
    output logic                       o_valid,
    output logic [prr_pkg::PCT_W-1:0]  o_percent_done,
    output logic                       o_report_due
);
    import prr_pkg::*;

    logic             r_valid;
    logic [PCT_W-1:0] r_pct;
    logic             r_due;
    logic [PCT_W-1:0] n_pct;
    logic             n_due;
    logic [PCT_W-1:0] s_step;

    always_comb begin
        s_step = (i_step == '0) ? {{(PCT_W-1){1'b0}}, 1'b1} : i_step;
        if (i_ctl.zero_total) begin
            n_pct = '0;
        end else if (i_ctl.full) begin
            n_pct = PCT_FULL;
        end else begin
            n_pct = i_q;
        end
        if (n_pct >= PCT_FULL) begin
            n_due = (i_ctl.last < PCT_FULL);
        end else if (n_pct < i_ctl.last) begin
            n_due = 1'b0;
        end else begin
            n_due = ((n_pct - i_ctl.last) >= s_step);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctl.valid;
        end
        r_pct <= n_pct;
        r_due <= n_due;
    end

    assign o_valid        = r_valid;
    assign o_percent_done = r_pct;
    assign o_report_due   = r_due;

endmodule

@@ rtl/core/progress_percent_reporter.sv @@
// ============================================================================
// progress_percent_reporter - byte counts to whole percent and report flag
// Pipeline: one input stage, eight quotient steps and one decision stage
// lie between an accepted word and its result strobe.
// Throughput: one word per cycle; busy stays low, the pipeline never stalls.
// The receiver must take every result in the cycle it appears (not enforced).
// Reset: synchronous, active low; clears the valid bits and sets the step to 1.
// ============================================================================
module progress_percent_reporter #(
    parameter int COUNT_BITS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // command side
    input  logic                       start,
    output logic                       busy,
    input  logic [COUNT_BITS-1:0]      i_bytes_written,
    input  logic [COUNT_BITS-1:0]      i_bytes_total,
    input  logic [prr_pkg::PCT_W-1:0]  i_last_percent,
    // step register write
    input  logic                       i_cfg_we,
    input  logic [prr_pkg::PCT_W-1:0]  i_cfg_wdata,
    // result side
    output logic                       o_valid,
    output logic [prr_pkg::PCT_W-1:0]  o_percent_done,
    output logic                       o_report_due
);
    import prr_pkg::*;

    // Step register: minimum rise between reports.
    logic [PCT_W-1:0] r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= {{(PCT_W-1){1'b0}}, 1'b1};
        end else if (i_cfg_we) begin
            r_step <= i_cfg_wdata;
        end
    end

    // Nothing ever holds the pipeline, so a word is taken on every start.
    assign busy = 1'b0;

    // Stage arrays: index 0 is the input register, index k the output of step k.
    t_ctl                  s_ctl [NUM_STEPS+1];
    logic [COUNT_BITS-1:0] s_t   [NUM_STEPS+1];
    logic [COUNT_BITS-1:0] s_w   [NUM_STEPS+1];
    logic [COUNT_BITS-1:0] s_tw  [NUM_STEPS+1];
    logic [COUNT_BITS-1:0] s_r   [NUM_STEPS+1];
    logic [PCT_W-1:0]      s_q   [NUM_STEPS+1];

    // Input stage: classify the word and seed the quotient. The top bit of
    // 100 leaves the remainder at w and the quotient at zero. The quotient
    // lane carries garbage for a zero total or a full count; the decision
    // stage ignores it then.
    t_ctl                  r_ctl0;
    logic [COUNT_BITS-1:0] r_t0, r_w0, r_tw0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl0.valid <= 1'b0;
        end else begin
            r_ctl0.valid <= start & ~busy;
        end
        r_ctl0.zero_total <= (i_bytes_total == '0);
        r_ctl0.full       <= (i_bytes_written >= i_bytes_total);
        r_ctl0.last       <= i_last_percent;
        r_t0  <= i_bytes_total;
        r_w0  <= i_bytes_written;
        r_tw0 <= i_bytes_total - i_bytes_written;
    end

    assign s_ctl[0] = r_ctl0;
    assign s_t[0]   = r_t0;
    assign s_w[0]   = r_w0;
    assign s_tw[0]  = r_tw0;
    assign s_r[0]   = r_w0;
    assign s_q[0]   = '0;

    // Quotient steps: one doubling or one add per stage, each reduced
    // below the total, so every stage holds a single compare and subtract.
    for (genvar k = 0; k < NUM_STEPS; k++) begin : g_step
        prr_step #(
            .COUNT_BITS (COUNT_BITS),
            .OP         (STEP_OPS[k])
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (s_ctl[k]),
            .i_t     (s_t[k]),
            .i_w     (s_w[k]),
            .i_tw    (s_tw[k]),
            .i_r     (s_r[k]),
            .i_q     (s_q[k]),
            .o_ctl   (s_ctl[k+1]),
            .o_t     (s_t[k+1]),
            .o_w     (s_w[k+1]),
            .o_tw    (s_tw[k+1]),
            .o_r     (s_r[k+1]),
            .o_q     (s_q[k+1])
        );
    end

    // Decision stage: final percentage and report flag, registered onto
    // the result ports for one cycle.
    prr_decide u_decide (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (s_ctl[NUM_STEPS]),
        .i_q            (s_q[NUM_STEPS]),
        .i_step         (r_step),
        .o_valid        (o_valid),
        .o_percent_done (o_percent_done),
        .o_report_due   (o_report_due)
    );

endmodule
